// File: rtl/dq_pkg.sv
// Package for the double-ended queue core: request/result payload types,
// operation and status codes, back-end state encoding. No dependencies.
package dq_pkg;

    // mode codes on the request channel
    localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [2:0] MODE_PUSH_REAR  = 3'd1;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [2:0] MODE_POP_REAR   = 3'd3;
    localparam logic [2:0] MODE_LIST       = 3'd4;

    // status codes on the result channel
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] value;
    } dq_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value_res;
        logic               last;
    } dq_res_t;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_LIST       = 3'd4
    } dq_op_kind_t;

    // classified transaction handed from front end to back end
    typedef struct packed {
        dq_op_kind_t        kind;
        logic signed [31:0] value;
    } dq_op_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic   valid;
        dq_op_t op;
    } dq_head_t;

    typedef enum logic [1:0] {
        BK_RUN  = 2'b01,
        BK_LIST = 2'b10
    } dq_bk_state_t;

endpackage

// File: rtl/dq_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/dq_front.sv
// Front end of the deque core: accepts requests, classifies the mode and
// holds up to two transactions for the back end. Depends on dq_pkg.
module dq_front
    import dq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dq_req_t  req,
    output logic     busy,
    output dq_head_t head,
    input  logic     deq
);

    logic [1:0]  fill_reg, fill_next;
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    dq_op_t      slot_reg [2];
    dq_op_kind_t kind;
    logic        mode_ok;
    logic        enq;
    logic        do_deq;

    always_comb
    begin
        mode_ok = 1'b1;
        kind    = OP_PUSH_FRONT;
        case (req.mode)
            MODE_PUSH_FRONT: kind = OP_PUSH_FRONT;
            MODE_PUSH_REAR:  kind = OP_PUSH_REAR;
            MODE_POP_FRONT:  kind = OP_POP_FRONT;
            MODE_POP_REAR:   kind = OP_POP_REAR;
            MODE_LIST:       kind = OP_LIST;
            default:         mode_ok = 1'b0;  // unused modes are dropped here
        endcase
    end

    assign busy   = (fill_reg == 2'd2);
    assign enq    = start && !busy && mode_ok;
    assign do_deq = deq && (fill_reg != 2'd0);

    always_comb
    begin
        fill_next   = fill_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (enq)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (do_deq)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (enq && !do_deq)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (!enq && do_deq)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            fill_reg   <= fill_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            slot_reg[wr_ptr_reg] <= '{kind: kind, value: req.value};
        end
    end

    assign head.valid = (fill_reg != 2'd0);
    assign head.op    = slot_reg[rd_ptr_reg];

endmodule

// File: rtl/dq_back.sv
// Back end of the deque core: ring indices, entry RAM and list walker,
// with a registered result stage. Depends on dq_pkg and dq_ram.
module dq_back
    import dq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  dq_head_t head,
    output logic     deq,
    output logic     result_valid,
    output dq_res_t  result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    dq_bk_state_t  state_reg, state_next;
    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] list_idx_reg, list_idx_next;

    logic          res_valid_reg;
    logic [1:0]    status_reg;
    logic          last_reg;
    logic          rd_use_reg;

    logic          issue;
    logic [1:0]    iss_status;
    logic          iss_last;
    logic          iss_rd;

    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;
    logic          re;
    logic [AW-1:0] raddr;
    logic [31:0]   rdata;

    logic          full;
    logic          empty;
    logic          list_last;

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW+1)'(DEPTH))
        begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign list_last = ((CW'(list_idx_reg) + CW'(1)) == count_reg);

    always_comb
    begin
        state_next    = state_reg;
        front_next    = front_reg;
        count_next    = count_reg;
        list_idx_next = list_idx_reg;
        deq           = 1'b0;
        issue         = 1'b0;
        iss_status    = ST_OK;
        iss_last      = 1'b1;
        iss_rd        = 1'b0;
        we            = 1'b0;
        waddr         = front_reg;
        wdata         = head.op.value;
        re            = 1'b0;
        raddr         = front_reg;

        case (state_reg)
            BK_RUN:
            begin
                if (head.valid)
                begin
                    deq   = 1'b1;
                    issue = 1'b1;
                    case (head.op.kind)
                        OP_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                iss_status = ST_OVERFLOW;
                            end
                            else
                            begin
                                front_next = (front_reg == '0) ? AW'(DEPTH - 1)
                                                               : front_reg - AW'(1);
                                we         = 1'b1;
                                waddr      = front_next;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_PUSH_REAR:
                        begin
                            if (full)
                            begin
                                iss_status = ST_OVERFLOW;
                            end
                            else
                            begin
                                we         = 1'b1;
                                waddr      = ring_add(front_reg, count_reg[AW-1:0]);
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                iss_status = ST_UNDERFLOW;
                            end
                            else
                            begin
                                re         = 1'b1;
                                iss_rd     = 1'b1;
                                raddr      = front_reg;
                                front_next = ring_add(front_reg, AW'(1));
                                count_next = count_reg - CW'(1);
                            end
                        end
                        OP_POP_REAR:
                        begin
                            if (empty)
                            begin
                                iss_status = ST_UNDERFLOW;
                            end
                            else
                            begin
                                re         = 1'b1;
                                iss_rd     = 1'b1;
                                raddr      = ring_add(front_reg,
                                                      count_reg[AW-1:0] - AW'(1));
                                count_next = count_reg - CW'(1);
                            end
                        end
                        OP_LIST:
                        begin
                            if (empty)
                            begin
                                iss_status = ST_EMPTY;
                            end
                            else
                            begin
                                // first entry now, the rest walked in BK_LIST
                                re       = 1'b1;
                                iss_rd   = 1'b1;
                                raddr    = front_reg;
                                iss_last = (count_reg == CW'(1));
                                if (count_reg != CW'(1))
                                begin
                                    state_next    = BK_LIST;
                                    list_idx_next = AW'(1);
                                end
                            end
                        end
                        default:
                        begin
                            issue = 1'b0;
                        end
                    endcase
                end
            end
            BK_LIST:
            begin
                issue    = 1'b1;
                re       = 1'b1;
                iss_rd   = 1'b1;
                raddr    = ring_add(front_reg, list_idx_reg);
                iss_last = list_last;
                if (list_last)
                begin
                    state_next = BK_RUN;
                end
                else
                begin
                    list_idx_next = list_idx_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_RUN;
            front_reg     <= '0;
            count_reg     <= '0;
            list_idx_reg  <= '0;
            res_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            last_reg      <= 1'b0;
            rd_use_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            list_idx_reg  <= list_idx_next;
            res_valid_reg <= issue;
            status_reg    <= iss_status;
            last_reg      <= iss_last;
            rd_use_reg    <= iss_rd;
        end
    end

    dq_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign result_valid     = res_valid_reg;
    assign result.status    = status_reg;
    assign result.value_res = rd_use_reg ? $signed(rdata) : 32'sd0;
    assign result.last      = last_reg;

endmodule

// File: rtl/double_ended_queue_core.sv
// Top level of the bounded double-ended queue of signed 32-bit words.
// Depends on dq_pkg, dq_front, dq_back (which holds dq_ram).
//
// Request channel: req (mode, value) is taken at a rising edge where start
// is high and busy is low. Modes: push front, push rear, pop front, pop
// rear, list all; unused modes are taken and dropped without a result.
// Result channel: result (status, value_res, last) is valid for exactly one
// cycle while result_valid is high; the receiver cannot stall it.
// Push and pop give one result; list gives one result per held entry, the
// final one with last set, or a single empty-status result.
// Path: a taken transaction is written into the two-entry queue, then
// issued by the back end into the registered result stage, where the
// strobe rises (entry RAM read is registered alongside). Throughput:
// one push/pop per cycle, but a list holds the back end until its last entry.
// busy rises only while the two-entry queue is full.
// Reset: the queue is emptied (front index and count cleared); entry RAM
// contents are not cleared and need no clearing pass.
module double_ended_queue_core
    import dq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  dq_req_t req,
    output logic    result_valid,
    output dq_res_t result
);

    dq_head_t head;
    logic     deq;

    dq_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .head  (head),
        .deq   (deq)
    );

    dq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .deq          (deq),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// File: rtl/dq_checker.sv
// Port-level checks for double_ended_queue_core, attached by bind.
// Depends on dq_pkg.
module dq_checker
    import dq_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input dq_req_t req,
    input logic    result_valid,
    input dq_res_t result
);

    // error and empty results stand alone
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != ST_OK |-> result.last)
        else $error("error status without last");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != ST_OK |-> result.value_res == 32'sd0)
        else $error("error status with nonzero value");

    // a list streams one entry per cycle until last
    a_list_burst: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |=> result_valid)
        else $error("gap inside a list burst");

    // busy only comes up after a transaction was taken
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose with no transaction");

endmodule

bind double_ended_queue_core dq_checker u_dq_checker (.*);
